// ----- src/kmm_pkg.sv -----
// Package for the knight shortest-path engine: sequencer states, move offsets and limits.
package kmm_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR,
        S_POP,
        S_SQ,
        S_DIST,
        S_NB,
        S_DONE
    } t_state;

    localparam int MOVE_COUNT = 8;
    localparam int COL_STEP [MOVE_COUNT] = '{-2, -1, 1, 2, 2, 1, -1, -2};
    localparam int ROW_STEP [MOVE_COUNT] = '{1, 2, 2, 1, -1, -2, -2, -1};

    localparam int DIST_W = 6;
    localparam logic [DIST_W-1:0] MAX_DIST = 6'd63;
    localparam int COORD_IN_W = 3;

endpackage

// ----- src/kmm_step.sv -----
// Neighbour generator: applies one knight-move offset to a square and checks the board edge.
module kmm_step #(
    parameter int BOARD_SIDE = 8
) (
    input  logic [$clog2(BOARD_SIDE)-1:0]              i_col,
    input  logic [$clog2(BOARD_SIDE)-1:0]              i_row,
    input  logic [2:0]                                 i_k,
    output logic                                       o_ok,
    output logic [$clog2(BOARD_SIDE*BOARD_SIDE)-1:0]   o_sq,
    output logic [$clog2(BOARD_SIDE)-1:0]              o_col,
    output logic [$clog2(BOARD_SIDE)-1:0]              o_row
);
    import kmm_pkg::*;

    localparam int CW  = $clog2(BOARD_SIDE);
    localparam int SQW = $clog2(BOARD_SIDE * BOARD_SIDE);

    always_comb begin
        int nc;
        int nr;
        nc    = int'(i_col) + COL_STEP[i_k];
        nr    = int'(i_row) + ROW_STEP[i_k];
        o_ok  = (nc >= 0) && (nr >= 0) && (nc < BOARD_SIDE) && (nr < BOARD_SIDE);
        o_col = CW'(nc);
        o_row = CW'(nr);
        o_sq  = SQW'(nr * BOARD_SIDE + nc);
    end

endmodule

// ----- src/knight_min_moves_bfs.sv -----
// Knight shortest-path engine: sequencer, distance and visited memory, and square queue.
// Sequence: an off-board query goes straight to the done state. Otherwise a clearing pass
//   over every square comes first, then each dequeued square takes a queue read, a memory
//   read and, unless it is the goal, the neighbour loop; the search ends at the goal or when
//   the queue runs empty.
// Queries: one at a time. Reset: synchronous, active low; clears the sequencer, queue
//   pointers, move index, clear counter, found flag, neighbour strobe and output valid only.
module knight_min_moves_bfs #(
    parameter int BOARD_SIDE = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [kmm_pkg::COORD_IN_W-1:0] i_start_col,
    input  logic [kmm_pkg::COORD_IN_W-1:0] i_start_row,
    input  logic [kmm_pkg::COORD_IN_W-1:0] i_goal_col,
    input  logic [kmm_pkg::COORD_IN_W-1:0] i_goal_row,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [kmm_pkg::DIST_W-1:0]    o_move_count,
    output logic                          o_reachable
);
    import kmm_pkg::*;

    localparam int SQ  = BOARD_SIDE * BOARD_SIDE;
    localparam int CW  = $clog2(BOARD_SIDE);
    localparam int SQW = $clog2(SQ);
    localparam int PW  = $clog2(SQ + 1);

    // Sequencer and queue pointers.
    t_state                r_state, n_state;
    logic [PW-1:0]         r_head, r_tail;
    logic [3:0]            r_k;
    logic [SQW-1:0]        r_clr;
    logic                  r_nb_live;
    logic                  r_found;
    logic                  r_out_valid;

    // Payload registers of the search.
    logic [CW-1:0]         r_goal_col, r_goal_row;
    logic [CW-1:0]         r_col, r_row;
    logic [SQW-1:0]        r_start_sq;
    logic [SQW-1:0]        r_nb_sq;
    logic [CW-1:0]         r_nb_col, r_nb_row;
    logic [DIST_W-1:0]     r_dist, r_count;
    logic [DIST_W-1:0]     r_move_count;
    logic                  r_reachable;

    // Memories, each with a registered read port. The top bit of a distance entry is the
    // visited mark of that square for the current query.
    logic [DIST_W:0]       dist_mem [SQ];
    logic [2*CW-1:0]       fifo_mem [SQ];
    logic [DIST_W:0]       r_dist_rd;
    logic [2*CW-1:0]       r_fifo_rd;

    // Control decoded from the state.
    logic                  in_acc;
    logic                  off_board;
    logic                  out_free;
    logic                  at_goal;
    logic                  queue_empty;
    logic                  nb_ok;
    logic [SQW-1:0]        nb_sq;
    logic [CW-1:0]         nb_col, nb_row;
    logic                  mark;
    logic                  dist_we, fifo_we;
    logic [SQW-1:0]        dist_wa, fifo_wa;
    logic [SQW-1:0]        dist_ra;
    logic [DIST_W:0]       dist_wd;
    logic [2*CW-1:0]       fifo_wd;
    logic [SQW-1:0]        start_sq;
    logic [SQW-1:0]        rd_sq;
    logic [DIST_W-1:0]     next_dist;

    assign o_stall     = (r_state != S_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign off_board   = (int'(i_start_col) >= BOARD_SIDE) || (int'(i_start_row) >= BOARD_SIDE)
                      || (int'(i_goal_col) >= BOARD_SIDE) || (int'(i_goal_row) >= BOARD_SIDE);
    assign out_free    = !r_out_valid || !i_stall;
    assign queue_empty = (r_head == r_tail);
    assign at_goal     = (r_col == r_goal_col) && (r_row == r_goal_row);
    assign start_sq    = SQW'(int'(i_start_row) * BOARD_SIDE + int'(i_start_col));
    // The queue holds coordinates, so the square index is rebuilt with a constant multiply.
    assign rd_sq       = SQW'(int'(r_fifo_rd[2*CW-1:CW]) * BOARD_SIDE + int'(r_fifo_rd[CW-1:0]));
    assign next_dist   = (r_dist >= MAX_DIST) ? MAX_DIST : r_dist + DIST_W'(1);
    // The neighbour loop reads the visited marks; the dequeue reads the distance.
    assign dist_ra     = (r_state == S_NB) ? nb_sq : rd_sq;

    kmm_step #(
        .BOARD_SIDE (BOARD_SIDE)
    ) u_step (
        .i_col (r_col),
        .i_row (r_row),
        .i_k   (r_k[2:0]),
        .o_ok  (nb_ok),
        .o_sq  (nb_sq),
        .o_col (nb_col),
        .o_row (nb_row)
    );

    // A neighbour is claimed in the cycle after its read, when it is on the board and its
    // visited mark is still clear in this query.
    assign mark = r_nb_live && !r_dist_rd[DIST_W];

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = off_board ? S_DONE : S_CLR;
                end
            end
            S_CLR: begin
                if (r_clr == SQW'(SQ - 1)) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                n_state = queue_empty ? S_DONE : S_SQ;
            end
            S_SQ: begin
                n_state = S_DIST;
            end
            S_DIST: begin
                // The goal compare is made here, where the coordinates and the distance read have returned.
                n_state = at_goal ? S_DONE : S_NB;
            end
            S_NB: begin
                // Eight neighbour reads, then a last pass in which the final claim is written.
                if (r_k == 4'(MOVE_COUNT)) begin
                    n_state = S_POP;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory write port selection. The clearing pass wipes every visited mark and writes the
    // start square as visited at distance zero; the start square enters the queue on the
    // query transfer. Every later write comes from a claimed neighbour. The eight neighbours
    // of one square are distinct squares, so a claim written back never meets the read of
    // the next neighbour on the same entry, and no forwarding path is needed.
    always_comb begin
        dist_we = 1'b0;
        fifo_we = 1'b0;
        dist_wa = r_nb_sq;
        dist_wd = {1'b1, next_dist};
        fifo_wa = r_tail[SQW-1:0];
        fifo_wd = {r_nb_row, r_nb_col};
        case (r_state)
            S_IDLE: begin
                if (in_acc && !off_board) begin
                    fifo_we = 1'b1;
                    fifo_wa = '0;
                    fifo_wd = {CW'(i_start_row), CW'(i_start_col)};
                end
            end
            S_CLR: begin
                dist_we = 1'b1;
                dist_wa = r_clr;
                dist_wd = (r_clr == r_start_sq) ? {1'b1, DIST_W'(0)} : '0;
            end
            S_NB: begin
                dist_we = mark;
                fifo_we = mark && (int'(r_tail) < SQ);
            end
            default: begin
                dist_we = 1'b0;
                fifo_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            dist_mem[dist_wa] <= dist_wd;
        end
        r_dist_rd <= dist_mem[dist_ra];
    end

    always_ff @(posedge i_clk) begin
        if (fifo_we) begin
            fifo_mem[fifo_wa] <= fifo_wd;
        end
        r_fifo_rd <= fifo_mem[r_head[SQW-1:0]];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_k         <= '0;
            r_clr       <= '0;
            r_nb_live   <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_nb_live <= (r_state == S_NB) && (r_k < 4'(MOVE_COUNT)) && nb_ok;
            if (r_state == S_IDLE && in_acc) begin
                r_found <= 1'b0;
                r_head  <= '0;
                r_k     <= '0;
                r_clr   <= '0;
                if (off_board) begin
                    r_tail <= '0;
                end else begin
                    r_tail <= PW'(1);
                end
            end
            if (r_state == S_CLR) begin
                r_clr <= r_clr + SQW'(1);
            end
            if (r_state == S_POP && !queue_empty) begin
                r_head <= r_head + PW'(1);
            end
            if (r_state == S_DIST) begin
                r_k <= '0;
                if (at_goal) begin
                    r_found <= 1'b1;
                end
            end
            if (r_state == S_NB) begin
                r_k <= r_k + 4'd1;
                if (fifo_we) begin
                    r_tail <= r_tail + PW'(1);
                end
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_goal_col <= CW'(i_goal_col);
            r_goal_row <= CW'(i_goal_row);
            r_start_sq <= start_sq;
        end
        if (r_state == S_SQ) begin
            r_row <= r_fifo_rd[2*CW-1:CW];
            r_col <= r_fifo_rd[CW-1:0];
        end
        if (r_state == S_DIST) begin
            r_dist  <= r_dist_rd[DIST_W-1:0];
            r_count <= r_dist_rd[DIST_W-1:0];
        end
        if (r_state == S_NB) begin
            r_nb_sq  <= nb_sq;
            r_nb_col <= nb_col;
            r_nb_row <= nb_row;
        end
        if (r_state == S_DONE && out_free) begin
            r_move_count <= r_found ? r_count : '0;
            r_reachable  <= r_found;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_move_count = r_move_count;
    assign o_reachable  = r_reachable;

    // The queue never holds more squares than the board has.
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_tail) <= SQ)
        else $error("square queue tail beyond board size");

    // The read pointer never passes the write pointer.
    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail)
        else $error("square queue head passed tail");

    // A result is only presented after the sequencer has finished a query.
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside the done state");

    // A claimed neighbour always finds a free slot in the queue.
    a_claim_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mark |-> int'(r_tail) < SQ)
        else $error("claimed neighbour with a full square queue");

    // An unreachable answer always carries a zero count.
    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_reachable) |-> (o_move_count == '0))
        else $error("unreachable result with non-zero count");

endmodule

// ----- test/tb_knight_min_moves_bfs.sv -----
// Self-checking testbench for the knight shortest-path engine, with a BFS scoreboard.
`timescale 1ns / 100ps

module tb_knight_min_moves_bfs;

    import kmm_pkg::*;

    localparam int BOARD_SIDE  = 8;
    localparam int CLK_PERIOD  = 20;
    localparam int RESET_CYCLES = 12;
    // The drain after the last answer is longer than the slowest query: a clearing pass and a
    // search that dequeues every square.
    localparam int DRAIN_CYCLES = 13 * BOARD_SIDE * BOARD_SIDE + 16;
    // About 470 queries, each at the slowest engine time with the longest receiver stall and
    // the longest sender gap, still fit well within the limit.
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_QUERIES = 450;
    localparam int REPORT_LIMIT = 10;

    // One expected answer, together with the query that caused it, so that a mismatch
    // can be reported with its squares.
    typedef struct {
        logic [COORD_IN_W-1:0] start_col;
        logic [COORD_IN_W-1:0] start_row;
        logic [COORD_IN_W-1:0] goal_col;
        logic [COORD_IN_W-1:0] goal_row;
        logic [DIST_W-1:0]     moves;
        logic                  reach;
    } t_knight_answer;

    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_HELD
    } t_stall_mode;

    typedef enum int {
        QUERY_ANY,
        QUERY_SAME,
        QUERY_ONE_MOVE,
        QUERY_CORNER
    } t_query_kind;

    // The scoreboard runs its own breadth-first search for every accepted query and keeps
    // the answers in order of arrival; the engine handles one query at a time.
    class knight_score #(int SIDE = 8);
        localparam int SQUARES = SIDE * SIDE;

        bit                seen_square [SQUARES];
        logic [DIST_W-1:0] square_dist [SQUARES];
        int                square_queue [SQUARES];
        int                queue_head;
        int                queue_tail;

        t_knight_answer    pending_answers [$];
        int                queries;
        int                answers;
        int                mismatches;
        int                longest_path;
        int                unreachable_seen;

        function void enqueue_square(int sq);
            if (queue_tail < SQUARES) begin
                square_queue[queue_tail] = sq;
                queue_tail++;
            end
        endfunction

        // Least knight moves from start to goal; zero and not reachable when either square
        // lies off the board or the goal is never dequeued.
        function void predict_moves(ref t_knight_answer ans);
            int start_sq;
            int goal_sq;
            int sq;
            int col;
            int row;
            int next_col;
            int next_row;
            int next_sq;
            logic [DIST_W-1:0] path_len;
            ans.moves = '0;
            ans.reach = 1'b0;
            if (int'(ans.start_col) >= SIDE || int'(ans.start_row) >= SIDE ||
                int'(ans.goal_col) >= SIDE || int'(ans.goal_row) >= SIDE) begin
                return;
            end
            start_sq = int'(ans.start_row) * SIDE + int'(ans.start_col);
            goal_sq  = int'(ans.goal_row) * SIDE + int'(ans.goal_col);
            foreach (seen_square[i]) seen_square[i] = 1'b0;
            queue_head = 0;
            queue_tail = 0;
            seen_square[start_sq] = 1'b1;
            square_dist[start_sq] = '0;
            enqueue_square(start_sq);
            while (queue_head < queue_tail) begin
                sq       = square_queue[queue_head];
                col      = sq % SIDE;
                row      = sq / SIDE;
                path_len = square_dist[sq];
                queue_head++;
                if (sq == goal_sq) begin
                    ans.moves = path_len;
                    ans.reach = 1'b1;
                    return;
                end
                for (int k = 0; k < MOVE_COUNT; k++) begin
                    next_col = col + COL_STEP[k];
                    next_row = row + ROW_STEP[k];
                    if (next_col < 0 || next_row < 0 || next_col >= SIDE || next_row >= SIDE)
                        continue;
                    next_sq = next_row * SIDE + next_col;
                    if (seen_square[next_sq])
                        continue;
                    seen_square[next_sq] = 1'b1;
                    square_dist[next_sq] = (path_len >= MAX_DIST) ? MAX_DIST
                                                                  : path_len + DIST_W'(1);
                    enqueue_square(next_sq);
                end
            end
        endfunction

        function void note_query(logic [COORD_IN_W-1:0] sc, logic [COORD_IN_W-1:0] sr,
                                 logic [COORD_IN_W-1:0] gc, logic [COORD_IN_W-1:0] gr);
            t_knight_answer ans;
            ans.start_col = sc;
            ans.start_row = sr;
            ans.goal_col  = gc;
            ans.goal_row  = gr;
            predict_moves(ans);
            if (ans.reach && int'(ans.moves) > longest_path) longest_path = int'(ans.moves);
            if (!ans.reach) unreachable_seen++;
            pending_answers.push_back(ans);
            queries++;
        endfunction

        function void check_answer(logic [DIST_W-1:0] moves, logic reach);
            t_knight_answer want;
            answers++;
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Answer with no query outstanding: moves %0d reachable %0b",
                             moves, reach);
                return;
            end
            want = pending_answers.pop_front();
            if (moves !== want.moves || reach !== want.reach) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Mismatch for (%0d,%0d)->(%0d,%0d): ",
                             want.start_col, want.start_row, want.goal_col, want.goal_row,
                             "moves %0d/%0d reachable %0b/%0b (expected/actual)",
                             want.moves, moves, want.reach, reach);
            end
        endfunction

        function int outstanding();
            return pending_answers.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [COORD_IN_W-1:0] i_start_col;
    logic [COORD_IN_W-1:0] i_start_row;
    logic [COORD_IN_W-1:0] i_goal_col;
    logic [COORD_IN_W-1:0] i_goal_row;
    logic                  o_valid;
    logic                  i_stall;
    logic [DIST_W-1:0]     o_move_count;
    logic                  o_reachable;

    knight_score #(BOARD_SIDE) scoreboard = new;
    int cycle_count = 0;
    int directed_count;

    knight_min_moves_bfs #(
        .BOARD_SIDE(BOARD_SIDE)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_start_col (i_start_col),
        .i_start_row (i_start_row),
        .i_goal_col  (i_goal_col),
        .i_goal_row  (i_goal_row),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_move_count(o_move_count),
        .o_reachable (o_reachable)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // The run is bounded by a plain cycle counter: a hung engine ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d answers outstanding.",
                     cycle_count, scoreboard.outstanding());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Answers are sampled at the rising edge, so the values seen are those that the engine
    // held through the preceding cycle. A transfer happens when valid is high and the
    // receiver is not stalling.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            scoreboard.check_answer(o_move_count, o_reachable);
    end

    // The receiver keeps its own pattern: stretches with no stall at all, stretches of
    // sparse random stalls, and short runs of a held level. Changes are made at the falling
    // edge only.
    initial begin : receiver_stall
        t_stall_mode mode;
        int          run_len;
        logic        level;
        i_stall = 1'b0;
        forever begin
            mode    = t_stall_mode'($urandom_range(0, 2));
            run_len = (mode == STALL_HELD) ? $urandom_range(1, 25) : $urandom_range(20, 300);
            level   = 1'($urandom_range(0, 1));
            repeat (run_len) begin
                @(negedge i_clk);
                case (mode)
                    STALL_NONE:   i_stall = 1'b0;
                    STALL_SPARSE: i_stall = ($urandom_range(0, 3) == 0);
                    default:      i_stall = level;
                endcase
            end
        end
    end

    // Present one query at the falling edge and hold it until the engine takes it. Valid
    // is left high, so that a following call gives back-to-back queries.
    task automatic send_query(input logic [COORD_IN_W-1:0] sc, input logic [COORD_IN_W-1:0] sr,
                              input logic [COORD_IN_W-1:0] gc, input logic [COORD_IN_W-1:0] gr);
        @(negedge i_clk);
        i_valid     = 1'b1;
        i_start_col = sc;
        i_start_row = sr;
        i_goal_col  = gc;
        i_goal_row  = gr;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        scoreboard.note_query(sc, sr, gc, gr);
    endtask

    // Drop valid for a number of cycles; the payload wanders meanwhile, as it is ignored.
    task automatic sender_gap(input int cycles);
        @(negedge i_clk);
        i_valid     = 1'b0;
        i_start_col = COORD_IN_W'($urandom);
        i_start_row = COORD_IN_W'($urandom);
        i_goal_col  = COORD_IN_W'($urandom);
        i_goal_row  = COORD_IN_W'($urandom);
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Hold the sender off until the engine has answered every query that it took.
    task automatic wait_for_answers();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (scoreboard.outstanding() != 0) @(posedge i_clk);
    endtask

    // Random query with a bias towards the interesting shapes: a goal equal to the start,
    // a goal one knight move away, and corner squares. The rest are uniform over the board.
    task automatic send_random_query();
        t_query_kind           kind;
        int                    pick;
        int                    k;
        int                    nc;
        int                    nr;
        logic [COORD_IN_W-1:0] sc;
        logic [COORD_IN_W-1:0] sr;
        logic [COORD_IN_W-1:0] gc;
        logic [COORD_IN_W-1:0] gr;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       kind = QUERY_SAME;
            1:       kind = QUERY_ONE_MOVE;
            2:       kind = QUERY_CORNER;
            default: kind = QUERY_ANY;
        endcase
        sc = COORD_IN_W'($urandom_range(0, BOARD_SIDE - 1));
        sr = COORD_IN_W'($urandom_range(0, BOARD_SIDE - 1));
        gc = COORD_IN_W'($urandom_range(0, BOARD_SIDE - 1));
        gr = COORD_IN_W'($urandom_range(0, BOARD_SIDE - 1));
        case (kind)
            QUERY_SAME: begin
                gc = sc;
                gr = sr;
            end
            QUERY_ONE_MOVE: begin
                // Every square has at least two knight moves that stay on the board.
                do begin
                    k  = $urandom_range(0, MOVE_COUNT - 1);
                    nc = int'(sc) + COL_STEP[k];
                    nr = int'(sr) + ROW_STEP[k];
                end while (nc < 0 || nr < 0 || nc >= BOARD_SIDE || nr >= BOARD_SIDE);
                gc = COORD_IN_W'(nc);
                gr = COORD_IN_W'(nr);
            end
            QUERY_CORNER: begin
                sc = $urandom_range(0, 1) ? COORD_IN_W'(BOARD_SIDE - 1) : '0;
                sr = $urandom_range(0, 1) ? COORD_IN_W'(BOARD_SIDE - 1) : '0;
            end
            default: ;
        endcase
        send_query(sc, sr, gc, gr);
    endtask

    initial begin : stimulus
        int   burst_left;
        logic failed;

        // Every input is known from time zero, while the reset is held active.
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_start_col = '0;
        i_start_row = '0;
        i_goal_col  = '0;
        i_goal_row  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        sender_gap(3);

        // Directed queries, sent back to back. The first reaches a goal equal to its start.
        send_query(3'd0, 3'd0, 3'd0, 3'd0);
        send_query(3'd7, 3'd7, 3'd7, 3'd7);
        // Corner to opposite corner in both directions, and across the other diagonal.
        send_query(3'd0, 3'd0, 3'd7, 3'd7);
        send_query(3'd7, 3'd7, 3'd0, 3'd0);
        send_query(3'd7, 3'd0, 3'd0, 3'd7);
        send_query(3'd0, 3'd7, 3'd7, 3'd0);
        // A corner to its diagonal neighbour is the awkward four-move case.
        send_query(3'd0, 3'd0, 3'd1, 3'd1);
        send_query(3'd7, 3'd7, 3'd6, 3'd6);
        // An orthogonal neighbour, then single moves along both offset shapes.
        send_query(3'd0, 3'd0, 3'd1, 3'd0);
        send_query(3'd0, 3'd0, 3'd1, 3'd2);
        send_query(3'd0, 3'd0, 3'd2, 3'd1);
        send_query(3'd7, 3'd7, 3'd5, 3'd6);
        // Centre squares, where all eight offsets stay on the board.
        send_query(3'd3, 3'd3, 3'd4, 3'd4);
        send_query(3'd4, 3'd3, 3'd3, 3'd4);
        // Edges: each coordinate at both of its extremes; then an interior square as its own goal.
        send_query(3'd7, 3'd0, 3'd7, 3'd7);
        send_query(3'd0, 3'd7, 3'd0, 3'd0);
        send_query(3'd5, 3'd2, 3'd5, 3'd2);
        directed_count = scoreboard.queries;
        wait_for_answers();

        // Random queries in bursts, with random gaps between them, and once in a while a
        // pause until the engine has answered everything it holds.
        burst_left = 0;
        for (int n = 0; n < RANDOM_QUERIES; n++) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 3) != 0)
                    sender_gap($urandom_range(1, 30));
                burst_left = $urandom_range(1, 8);
            end
            send_random_query();
            burst_left--;
            if (n % 100 == 50)
                wait_for_answers();
        end

        // Let the last answers arrive, then watch for a while longer for any stray one.
        wait_for_answers();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d answers to %0d queries (%0d directed); ",
                 scoreboard.answers, scoreboard.queries, directed_count,
                 "longest path %0d moves, %0d unreachable.",
                 scoreboard.longest_path, scoreboard.unreachable_seen);
        $display("%0d mismatches over %0d cycles.", scoreboard.mismatches, cycle_count);
        failed = (scoreboard.mismatches != 0) || (scoreboard.outstanding() != 0);
        if (!failed) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
